// ===== rtl/sld_pkg.sv =====
// Shared types and constants for the sync/length/CRC-8 frame deframer.
`default_nettype none
package sld_pkg;

  localparam int unsigned MAX_FRAME_BYTES_DEF = 64;

  localparam logic [7:0] SYNC_BYTE_RST = 8'd200;
  localparam logic [7:0] CRC_POLY_RST  = 8'd213;
  localparam logic [7:0] MIN_LENGTH    = 8'd2;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_BYTE = 1'b0,
    CFG_CRC_POLY  = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_LEN    = 2'd1,
    PH_GATHER = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_INCOMPLETE = 2'd0,
    ST_READY      = 2'd1,
    ST_INVALID    = 2'd2
  } status_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] frame_type;
    logic [7:0] payload_len;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/sld_crc8.sv =====
// One-byte CRC-8 update, MSB first, programmable generator polynomial.
`default_nettype none
module sld_crc8 (
  input  wire logic [7:0] crc_in,
  input  wire logic [7:0] data_in,
  input  wire logic [7:0] poly,
  output logic      [7:0] crc_out
);

  always_comb begin
    logic [7:0] c;
    c = crc_in ^ data_in;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule
`default_nettype wire

// ===== rtl/sld_core.sv =====
// Frame state machine: sync hunt, length check, byte count, CRC and held results.
`default_nettype none
module sld_core #(
  parameter int unsigned MAX_FRAME_BYTES = sld_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step_en,
  input  wire logic [7:0]       rx_byte,
  input  wire logic [7:0]       sync_byte,
  input  wire logic [7:0]       crc_poly,
  output sld_pkg::result_t      result
);
  import sld_pkg::*;

  localparam logic [8:0] MAX_TOTAL = 9'(MAX_FRAME_BYTES);

  phase_t     phase_r, phase_nxt;
  logic [7:0] bytes_seen_r, bytes_seen_nxt;
  logic [7:0] decl_len_r, decl_len_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic [7:0] pend_type_r, pend_type_nxt;
  logic [7:0] held_type_r, held_type_nxt;
  logic [7:0] held_len_r, held_len_nxt;
  status_t    status;

  logic [7:0] crc_upd;
  logic [8:0] total;
  logic       len_bad;
  logic [7:0] cnt_inc;
  logic       last_byte;

  sld_crc8 u_crc (
    .crc_in  (crc_r),
    .data_in (rx_byte),
    .poly    (crc_poly),
    .crc_out (crc_upd)
  );

  assign total     = {1'b0, rx_byte} + 9'd2;
  assign len_bad   = (rx_byte < MIN_LENGTH) || (total > MAX_TOTAL);
  // count never passes the declared length, so it cannot wrap
  assign cnt_inc   = bytes_seen_r + 8'd1;
  assign last_byte = !(cnt_inc < decl_len_r);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_LEN: begin
        phase_nxt = len_bad ? PH_HUNT : PH_GATHER;
      end
      PH_GATHER: begin
        phase_nxt = last_byte ? PH_HUNT : PH_GATHER;
      end
      default: begin
        phase_nxt = (rx_byte == sync_byte) ? PH_LEN : PH_HUNT;
      end
    endcase
  end

  // datapath and status
  always_comb begin
    bytes_seen_nxt = bytes_seen_r;
    decl_len_nxt   = decl_len_r;
    crc_nxt        = crc_r;
    pend_type_nxt  = pend_type_r;
    held_type_nxt  = held_type_r;
    held_len_nxt   = held_len_r;
    status         = ST_INCOMPLETE;
    case (phase_r)
      PH_LEN: begin
        if (len_bad) begin
          bytes_seen_nxt = '0;
          decl_len_nxt   = '0;
          crc_nxt        = '0;
          pend_type_nxt  = '0;
          status         = ST_INVALID;
        end else begin
          decl_len_nxt   = rx_byte;
          bytes_seen_nxt = '0;
          crc_nxt        = '0;
        end
      end
      PH_GATHER: begin
        if (!last_byte) begin
          bytes_seen_nxt = cnt_inc;
          crc_nxt        = crc_upd;
          if (cnt_inc == 8'd1) begin
            pend_type_nxt = rx_byte;
          end
        end else begin
          held_type_nxt  = pend_type_r;
          held_len_nxt   = decl_len_r - MIN_LENGTH;
          bytes_seen_nxt = '0;
          decl_len_nxt   = '0;
          crc_nxt        = '0;
          pend_type_nxt  = '0;
          status         = (crc_r == rx_byte) ? ST_READY : ST_INVALID;
        end
      end
      default: begin
        // hunting clears the frame context on every byte
        bytes_seen_nxt = '0;
        decl_len_nxt   = '0;
        crc_nxt        = '0;
        pend_type_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      bytes_seen_r <= '0;
      decl_len_r   <= '0;
      crc_r        <= '0;
      pend_type_r  <= '0;
      held_type_r  <= '0;
      held_len_r   <= '0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      bytes_seen_r <= bytes_seen_nxt;
      decl_len_r   <= decl_len_nxt;
      crc_r        <= crc_nxt;
      pend_type_r  <= pend_type_nxt;
      held_type_r  <= held_type_nxt;
      held_len_r   <= held_len_nxt;
    end
  end

  assign result.status      = status;
  assign result.frame_type  = held_type_nxt;
  assign result.payload_len = held_len_nxt;

endmodule
`default_nettype wire

// ===== rtl/sync_length_crc8_frame_deframer.sv =====
// An accepted item passes the input register, then the result register that offers it.
// Throughput: one item per cycle unless out_stall is high with both registers full.
// The frame state and CRC update between the input and result registers.
// Reset (rst_n low, synchronous): empties both registers, returns to sync hunt,
// clears held type and length, and loads sync byte 200 and polynomial 213.
`default_nettype none
module sync_length_crc8_frame_deframer #(
  parameter int unsigned MAX_FRAME_BYTES = sld_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [sld_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sld_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [7:0]                       in_rx_byte,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [1:0]                            out_status,
  output logic [7:0]                            out_frame_type,
  output logic [7:0]                            out_payload_len
);
  import sld_pkg::*;

  logic [7:0] sync_r, poly_r;
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       out_valid_r;
  result_t    out_r;
  result_t    core_res;
  logic       adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= SYNC_BYTE_RST;
      poly_r <= CRC_POLY_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SYNC_BYTE: sync_r <= cfg_wdata;
        CFG_CRC_POLY:  poly_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // the held item moves on when the result register is empty or being taken
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  sld_core #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (adv),
    .rx_byte   (s1_byte_r),
    .sync_byte (sync_r),
    .crc_poly  (poly_r),
    .result    (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= core_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_r.status;
  assign out_frame_type  = out_r.frame_type;
  assign out_payload_len = out_r.payload_len;

endmodule
`default_nettype wire

// ===== rtl/sld_checker.sv =====
// Port-level checks for the deframer, bound to the top level.
`default_nettype none
module sld_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] out_status,
  input wire logic [7:0] out_frame_type,
  input wire logic [7:0] out_payload_len
);
  import sld_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_frame_type) && $stable(out_payload_len))
    else $error("stalled item changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_payload_len != 8'd255)
    else $error("payload length out of range");

endmodule

bind sync_length_crc8_frame_deframer sld_checker u_sld_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_frame_type  (out_frame_type),
  .out_payload_len (out_payload_len)
);
`default_nettype wire
